### rtl/assert_macros.svh
// Assertion macros shared by the setpoint shaper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the cycle where ante holds.
`define SSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sss_pkg.sv
// Types, constants and helper functions of the stick setpoint shaper.
package sss_pkg;

  localparam int STICK_W = 16;
  localparam int ANGLE_W = 15;
  localparam int PROD_W  = STICK_W + ANGLE_W;
  localparam int WIDE_W  = 40;
  localparam int ACC6_W  = 25;
  localparam int QUOT_W  = 25;
  localparam int REM_W   = 10;
  localparam int CNT_W   = 5;
  localparam int START_W = 11;
  localparam int HOLD_W  = 9;

  localparam int MUL_STEPS = ANGLE_W;
  localparam int DIV_STEPS = QUOT_W;

  localparam logic [ANGLE_W-1:0]        ANGLE_MAX     = 15'd25736;
  localparam logic signed [STICK_W-1:0] ANGLE_MAX_S   = 16'sd25736;
  localparam logic [ANGLE_W-1:0]        ANGLE_RESET   = 15'd4096;
  localparam logic [START_W-1:0]        AUTO_DELAY_TICKS = 11'd1500;
  localparam logic [HOLD_W-1:0]         EXIT_HOLD_TICKS  = 9'd250;
  localparam logic signed [STICK_W-1:0] MODE_HALF     = 16'sd8192;
  localparam logic signed [STICK_W-1:0] Q_ONE         = 16'sd16384;
  localparam logic [ANGLE_W-1:0]        THR_LOW_MAX   = 15'd1638;
  localparam logic [STICK_W-1:0]        STICK_BIG_MIN = 16'd9831;
  localparam logic [PROD_W-1:0]         PROD_ROUND    = 31'd8192;
  localparam logic [WIDE_W-1:0]         YAW_ROUND     = 40'd5120000;
  localparam logic [WIDE_W-1:0]         YAW_ROUND_NEG = 40'd5120001;
  localparam logic [REM_W:0]            YAW_DIV       = 11'd625;

  typedef enum logic [1:0] {
    REG_MAX_ROLL  = 2'd0,
    REG_MAX_PITCH = 2'd1,
    REG_MAX_YAW   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUMA,
    ST_SUMB,
    ST_SUMC,
    ST_ROUND,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } ser_ctl_t;

  typedef struct packed {
    logic signed [STICK_W-1:0] roll_cmd;
    logic signed [STICK_W-1:0] pitch_cmd;
    logic signed [STICK_W-1:0] yaw_cmd;
    logic signed [STICK_W-1:0] throttle_cmd;
    logic signed [STICK_W-1:0] mode_channel;
  } in_item_t;

  typedef struct packed {
    logic signed [STICK_W-1:0] roll_desired;
    logic signed [STICK_W-1:0] pitch_desired;
    logic signed [STICK_W-1:0] yaw_desired;
    logic [ANGLE_W-1:0]        throttle_out;
    logic                      auto_mode;
    logic                      exit_command;
  } out_item_t;

  function automatic logic [STICK_W-1:0] stick_mag(input logic signed [STICK_W-1:0] v);
    logic [STICK_W-1:0] neg;
    neg = STICK_W'(-v);
    return v[STICK_W-1] ? neg : v;
  endfunction

  function automatic logic signed [STICK_W-1:0] clamp_sign(input logic [QUOT_W-1:0] q,
                                                           input logic neg);
    logic [ANGLE_W-1:0] qc;
    logic [STICK_W-1:0] mag;
    qc  = (q > QUOT_W'(ANGLE_MAX)) ? ANGLE_MAX : q[ANGLE_W-1:0];
    mag = {1'b0, qc};
    return neg ? STICK_W'(-mag) : mag;
  endfunction

  function automatic logic signed [STICK_W-1:0] round_angle(input logic [PROD_W-1:0] prod,
                                                            input logic neg);
    logic [PROD_W-1:0] rsum;
    rsum = prod + PROD_ROUND;
    return clamp_sign(QUOT_W'(rsum[PROD_W-1:14]), neg);
  endfunction

endpackage

### rtl/sss_mul.sv
// Shift-and-add multiplier: one multiplier bit per step, narrow adder.
module sss_mul import sss_pkg::*; (
  input  logic               clk,
  input  ser_ctl_t           ctl,
  input  logic [STICK_W-1:0] mcand,
  input  logic [ANGLE_W-1:0] mplier,
  output logic [PROD_W-1:0]  prod
);

  logic [STICK_W-1:0] mc;
  logic [STICK_W-1:0] hi;
  logic [ANGLE_W-1:0] lo;
  logic [STICK_W:0]   psum;

  assign psum = {1'b0, hi} + (lo[0] ? {1'b0, mc} : {(STICK_W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mc <= mcand;
      hi <= '0;
      lo <= mplier;
    end else if (ctl.step) begin
      hi <= psum[STICK_W:1];
      lo <= {psum[0], lo[ANGLE_W-1:1]};
    end
  end

  assign prod = {hi, lo};

endmodule

### rtl/sss_div.sv
// Restoring divider by the yaw scale constant: one quotient bit per step.
module sss_div import sss_pkg::*; (
  input  logic              clk,
  input  ser_ctl_t          ctl,
  input  logic [QUOT_W-1:0] dividend,
  output logic [QUOT_W-1:0] quot
);

  logic [QUOT_W-1:0] q;
  logic [REM_W-1:0]  r;
  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              ge;

  assign trial = {r, q[QUOT_W-1]};
  assign ge    = trial >= YAW_DIV;
  assign diff  = trial - YAW_DIV;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= dividend;
      r <= '0;
    end else if (ctl.step) begin
      r <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      q <= {q[QUOT_W-2:0], ge};
    end
  end

  assign quot = q;

endmodule

### rtl/stick_setpoint_shaper_core.sv
// Stick setpoint shaper top level: sequencer, serial datapath, state and output register.
// Steps per request: accept, multiply, sums A to C, round, divide, then load the output register once it is free.
// One request at a time: the next is accepted only after the output register has taken the result,
// and the pace is set by the 15-step serial multipliers and the 25-step serial divider of the yaw path.
// Reset (rst, synchronous): angle registers go to 4096, yaw and counters to zero.
`include "assert_macros.svh"

module stick_setpoint_shaper_core import sss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [ANGLE_W-1:0] cfg_data
);

  state_t                    state;
  state_t                    state_next;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          cnt_next;
  ser_ctl_t                  mul_ctl;
  ser_ctl_t                  div_ctl;
  logic                      done_load;
  logic                      out_free;

  logic [ANGLE_W-1:0]        max_roll;
  logic [ANGLE_W-1:0]        max_pitch;
  logic [ANGLE_W-1:0]        max_yaw;

  in_item_t                  in_reg;
  logic signed [STICK_W-1:0] yaw_acc;
  logic [START_W-1:0]        startup_ticks;
  logic                      auto_flag;
  logic                      exit_waiting;
  logic [HOLD_W-1:0]         exit_hold;
  logic                      exit_flag;

  logic [PROD_W-1:0]         roll_prod;
  logic [PROD_W-1:0]         pitch_prod;
  logic [PROD_W-1:0]         yaw_prod;
  logic [QUOT_W-1:0]         yaw_quot;

  logic signed [ACC6_W-1:0]  acc_w;
  logic signed [ACC6_W-1:0]  x1;
  logic signed [ACC6_W-1:0]  x2;
  logic signed [ACC6_W-1:0]  x;
  logic signed [PROD_W:0]    yaw_p;
  logic signed [PROD_W:0]    ps;
  logic signed [WIDE_W-1:0]  ps_w;
  logic signed [WIDE_W-1:0]  x_w;
  logic signed [WIDE_W-1:0]  y48;
  logic signed [WIDE_W-1:0]  n;
  logic [WIDE_W-1:0]         rsum;
  logic                      yaw_neg;
  logic signed [STICK_W-1:0] roll_q;
  logic signed [STICK_W-1:0] pitch_q;
  logic signed [STICK_W-1:0] yaw_new;

  logic [ANGLE_W-1:0]        thr_cl;
  logic                      gesture;
  logic                      auto_next;
  logic [START_W-1:0]        startup_next;
  logic                      waiting_next;
  logic [HOLD_W-1:0]         hold_next;
  logic                      flag_next;

  sss_mul u_mul_roll (
    .clk    (clk),
    .ctl    (mul_ctl),
    .mcand  (stick_mag(in_data.roll_cmd)),
    .mplier (max_roll),
    .prod   (roll_prod)
  );

  sss_mul u_mul_pitch (
    .clk    (clk),
    .ctl    (mul_ctl),
    .mcand  (stick_mag(in_data.pitch_cmd)),
    .mplier (max_pitch),
    .prod   (pitch_prod)
  );

  sss_mul u_mul_yaw (
    .clk    (clk),
    .ctl    (mul_ctl),
    .mcand  (stick_mag(in_data.yaw_cmd)),
    .mplier (max_yaw),
    .prod   (yaw_prod)
  );

  sss_div u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (rsum[WIDE_W-2:14]),
    .quot     (yaw_quot)
  );

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (cnt == CNT_W'(MUL_STEPS - 1)) state_next = ST_SUMA;
        else cnt_next = cnt + 1'b1;
      end
      ST_SUMA:  state_next = ST_SUMB;
      ST_SUMB:  state_next = ST_SUMC;
      ST_SUMC:  state_next = ST_ROUND;
      ST_ROUND: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_DONE;
        else cnt_next = cnt + 1'b1;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    mul_ctl.load = 1'b0;
    mul_ctl.step = 1'b0;
    div_ctl.load = 1'b0;
    div_ctl.step = 1'b0;
    done_load    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall     = 1'b0;
        mul_ctl.load = in_valid;
      end
      ST_MUL:   mul_ctl.step = 1'b1;
      ST_ROUND: div_ctl.load = 1'b1;
      ST_DIV:   div_ctl.step = 1'b1;
      ST_DONE:  done_load    = out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_roll  <= ANGLE_RESET;
      max_pitch <= ANGLE_RESET;
      max_yaw   <= ANGLE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_ROLL)  max_roll  <= cfg_data;
      if (cfg_index == REG_MAX_PITCH) max_pitch <= cfg_data;
      if (cfg_index == REG_MAX_YAW)   max_yaw   <= cfg_data;
    end
  end

  // yaw numerator: 600*2^14*acc + 48*yaw*max, then round and divide by 625*2^14
  assign acc_w = ACC6_W'(yaw_acc);
  assign yaw_p = signed'({1'b0, yaw_prod});
  assign ps_w  = WIDE_W'(ps);
  assign x_w   = WIDE_W'(x);
  assign rsum  = n[WIDE_W-1] ? ($unsigned(~n) + YAW_ROUND_NEG) : ($unsigned(n) + YAW_ROUND);

  always_ff @(posedge clk) begin
    if (mul_ctl.load) in_reg <= in_data;
    case (state)
      ST_SUMA: begin
        x1 <= (acc_w <<< 9) + (acc_w <<< 6);
        x2 <= (acc_w <<< 4) + (acc_w <<< 3);
        ps <= in_reg.yaw_cmd[STICK_W-1] ? -yaw_p : yaw_p;
      end
      ST_SUMB: begin
        x   <= x1 + x2;
        y48 <= (ps_w <<< 5) + (ps_w <<< 4);
      end
      ST_SUMC: begin
        n <= (x_w <<< 14) + y48;
      end
      ST_ROUND: begin
        yaw_neg <= n[WIDE_W-1];
        roll_q  <= round_angle(roll_prod, in_reg.roll_cmd[STICK_W-1]);
        pitch_q <= round_angle(pitch_prod, in_reg.pitch_cmd[STICK_W-1]);
      end
      default: begin
        yaw_neg <= yaw_neg;
      end
    endcase
  end

  assign yaw_new = clamp_sign(yaw_quot, yaw_neg);

  always_comb begin
    if (in_reg.throttle_cmd[STICK_W-1]) thr_cl = '0;
    else if (in_reg.throttle_cmd > Q_ONE) thr_cl = ANGLE_W'(Q_ONE);
    else thr_cl = in_reg.throttle_cmd[ANGLE_W-1:0];
  end

  assign gesture = (thr_cl <= THR_LOW_MAX)
                && (stick_mag(in_reg.roll_cmd) >= STICK_BIG_MIN)
                && (stick_mag(in_reg.yaw_cmd) >= STICK_BIG_MIN);

  always_comb begin
    startup_next = startup_ticks;
    auto_next    = auto_flag;
    if (startup_ticks < AUTO_DELAY_TICKS) startup_next = startup_ticks + 1'b1;
    else auto_next = in_reg.mode_channel > MODE_HALF;

    waiting_next = exit_waiting;
    hold_next    = exit_hold;
    flag_next    = exit_flag;
    if (gesture) begin
      if (!exit_waiting) begin
        waiting_next = 1'b1;
        hold_next    = '0;
      end else if (exit_hold >= EXIT_HOLD_TICKS) begin
        flag_next    = 1'b1;
        waiting_next = 1'b0;
      end else begin
        hold_next = exit_hold + 1'b1;
      end
    end else begin
      waiting_next = 1'b0;
      hold_next    = '0;
      flag_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_acc       <= '0;
      startup_ticks <= '0;
      auto_flag     <= 1'b0;
      exit_waiting  <= 1'b0;
      exit_hold     <= '0;
      exit_flag     <= 1'b0;
    end else if (done_load) begin
      yaw_acc       <= yaw_new;
      startup_ticks <= startup_next;
      auto_flag     <= auto_next;
      exit_waiting  <= waiting_next;
      exit_hold     <= hold_next;
      exit_flag     <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_data.roll_desired  <= roll_q;
      out_data.pitch_desired <= pitch_q;
      out_data.yaw_desired   <= yaw_new;
      out_data.throttle_out  <= thr_cl;
      out_data.auto_mode     <= auto_next;
      out_data.exit_command  <= flag_next;
    end
  end

  `SSS_ASSERT_IMP(a_out_after_done, $rose(out_valid), $past(state == ST_DONE), "result without done step")
  `SSS_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state == ST_MUL, "request not started")
  `SSS_ASSERT_IMP(a_yaw_range, 1'b1, (yaw_acc <= ANGLE_MAX_S) && (yaw_acc >= -ANGLE_MAX_S), "yaw beyond pi")
  `SSS_ASSERT_IMP(a_startup_cap, 1'b1, startup_ticks <= AUTO_DELAY_TICKS, "startup count overrun")

endmodule
